// ----- src/bpc_pkg.sv -----
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants for the block permutation cipher core.
// ----------------------------------------------------------------------------
package bpc_pkg;

  // Largest block the design is built for; the key holds sixteen entries.
  localparam int MAX_BLOCK = 16;
  localparam int KEY_SLOTS = 16;
  localparam int SIZE_CAP  = (MAX_BLOCK < KEY_SLOTS) ? MAX_BLOCK : KEY_SLOTS;

  localparam int IDX_W     = $clog2(SIZE_CAP);      // byte position in a block
  localparam int CNT_W     = $clog2(SIZE_CAP + 1);  // byte count, 0..SIZE_CAP
  localparam int KEY_W     = 4;                     // one key entry
  localparam int BS_W      = 5;                     // block_size register
  localparam int BYTE_W    = 8;
  localparam int KEYMAP_W  = KEY_SLOTS * KEY_W;
  localparam int NUM_BANKS = 2;                     // ping-pong block buffers
  localparam int BANK_W    = $clog2(NUM_BANKS);
  localparam int QCNT_W    = $clog2(NUM_BANKS + 1);

  // Configuration port
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 64;

  typedef enum logic [1:0] {
    REG_BLOCK_SIZE   = 2'd0,
    REG_DECRYPT_MODE = 2'd1,
    REG_KEY_MAP      = 2'd2,
    REG_PAD_BYTE     = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_block;
    logic              last_of_message;
  } out_item_t;

  // Front writes one byte into the bank being filled.
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic [BYTE_W-1:0] data;
  } wr_req_t;

  // Description of a closed block.
  typedef struct packed {
    logic [CNT_W-1:0] fill;
    logic [CNT_W-1:0] size;
    logic             eom;
  } blk_desc_t;

  typedef struct packed {
    logic      en;
    blk_desc_t desc;
  } push_req_t;

  // Back reads the head bank and releases it after the last byte.
  typedef struct packed {
    logic             pop;
    logic [IDX_W-1:0] idx;
  } rd_req_t;

  typedef struct packed {
    logic              valid;
    blk_desc_t         desc;
    logic [BYTE_W-1:0] data;
  } head_t;

endpackage

// ----- src/bpc_front.sv -----
// ----------------------------------------------------------------------------
// bpc_front
// Accepts message bytes, stores them into the open bank and closes a block
// when it is full or the message ends.
// ----------------------------------------------------------------------------
module bpc_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  output logic                   byte_ready,
  input  bpc_pkg::in_item_t      byte_data,
  input  logic [bpc_pkg::BS_W-1:0] block_size,
  input  logic                   q_full,
  output bpc_pkg::wr_req_t       wr,
  output bpc_pkg::push_req_t     push
);
  import bpc_pkg::*;

  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] fill_next;
  logic [CNT_W-1:0] fill_inc;
  logic [CNT_W-1:0] eff_size;
  logic             accept;
  logic             close;

  // Size zero acts as one; oversize saturates at the buffer depth.
  always_comb begin
    priority if (block_size == '0) begin
      eff_size = CNT_W'(1);
    end else if (block_size > BS_W'(SIZE_CAP)) begin
      eff_size = CNT_W'(SIZE_CAP);
    end else begin
      eff_size = CNT_W'(block_size);
    end
  end

  assign byte_ready = !q_full;
  assign accept     = byte_valid && byte_ready;
  assign fill_inc   = (fill < CNT_W'(SIZE_CAP)) ? fill + 1'b1 : fill;
  assign close      = (fill_inc >= eff_size) || byte_data.end_of_message;

  always_comb begin
    wr.en     = accept && (fill < CNT_W'(SIZE_CAP));
    wr.idx    = fill[IDX_W-1:0];
    wr.data   = byte_data.data_byte;
    push.en   = accept && close;
    push.desc = '{fill: fill_inc, size: eff_size, eom: byte_data.end_of_message};
    fill_next = fill;
    if (accept) begin
      fill_next = close ? '0 : fill_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

endmodule

// ----- src/bpc_queue.sv -----
// ----------------------------------------------------------------------------
// bpc_queue
// Two block buffers with their descriptors, used in ping-pong order between
// the front and the back.
// ----------------------------------------------------------------------------
module bpc_queue (
  input  logic               clk,
  input  logic               rst,
  input  bpc_pkg::wr_req_t   wr,
  input  bpc_pkg::push_req_t push,
  input  bpc_pkg::rd_req_t   rd,
  output logic               full,
  output bpc_pkg::head_t     head
);
  import bpc_pkg::*;

  logic [BYTE_W-1:0] bank_mem [NUM_BANKS][SIZE_CAP];
  blk_desc_t         desc [NUM_BANKS];
  logic [BANK_W-1:0] wptr;
  logic [BANK_W-1:0] rptr;
  logic [QCNT_W-1:0] count;

  assign full = (count == QCNT_W'(NUM_BANKS));

  always_comb begin
    head.valid = (count != '0);
    head.desc  = desc[rptr];
    head.data  = bank_mem[rptr][rd.idx];
  end

  // Buffer contents and descriptors carry no reset.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      bank_mem[wptr][wr.idx] <= wr.data;
    end
    if (push.en) begin
      desc[wptr] <= push.desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push.en) begin
        wptr <= (wptr == BANK_W'(NUM_BANKS - 1)) ? '0 : wptr + 1'b1;
      end
      if (rd.pop) begin
        rptr <= (rptr == BANK_W'(NUM_BANKS - 1)) ? '0 : rptr + 1'b1;
      end
      unique case ({push.en, rd.pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push.en |-> !full) else $error("block closed with both buffers held");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    rd.pop |-> head.valid) else $error("buffer released while none held");

endmodule

// ----- src/bpc_back.sv -----
// ----------------------------------------------------------------------------
// bpc_back
// Emits the head block through an output register, one permuted byte per
// cycle while the result port is not stalled.
// ----------------------------------------------------------------------------
module bpc_back (
  input  logic                        clk,
  input  logic                        rst,
  input  bpc_pkg::head_t              head,
  output bpc_pkg::rd_req_t            rd,
  input  logic                        decrypt_mode,
  input  logic [bpc_pkg::KEYMAP_W-1:0] key_map,
  input  logic [bpc_pkg::BYTE_W-1:0]  pad_byte,
  output logic                        res_valid,
  input  logic                        res_ready,
  output bpc_pkg::out_item_t          res_data
);
  import bpc_pkg::*;

  logic [IDX_W-1:0]  pos;
  logic [KEY_W-1:0]  key_e [SIZE_CAP];
  logic [KEY_W-1:0]  src_idx;
  logic              hit;
  logic              last;
  logic              advance;
  logic [BYTE_W-1:0] byte_val;

  always_comb begin
    for (int k = 0; k < SIZE_CAP; k++) begin
      key_e[k] = key_map[k*KEY_W +: KEY_W];
    end
  end

  // Find the source position for output position pos.
  always_comb begin
    hit     = 1'b0;
    src_idx = '0;
    if (decrypt_mode) begin
      src_idx = key_e[pos];
      hit     = CNT_W'(src_idx) < head.desc.size;
    end else begin
      // Scatter: the highest input index pointing here wins.
      for (int k = 0; k < SIZE_CAP; k++) begin
        if ((CNT_W'(k) < head.desc.size) && (key_e[k] == KEY_W'(pos))) begin
          hit     = 1'b1;
          src_idx = KEY_W'(k);
        end
      end
    end
  end

  assign byte_val = (hit && (CNT_W'(src_idx) < head.desc.fill)) ? head.data : pad_byte;
  assign last     = (CNT_W'(pos) + 1'b1) == head.desc.size;
  assign advance  = head.valid && (!res_valid || res_ready);

  always_comb begin
    rd.idx = src_idx[IDX_W-1:0];
    rd.pop = advance && last;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_data.out_byte        <= byte_val;
      res_data.last_of_block   <= last;
      res_data.last_of_message <= last && head.desc.eom;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      res_valid <= 1'b0;
    end else begin
      if (advance) begin
        pos <= last ? '0 : pos + 1'b1;
      end
      if (advance) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  a_pos_in_block: assert property (@(posedge clk) disable iff (rst)
    head.valid |-> (CNT_W'(pos) < head.desc.size)) else $error("position past block");

  a_pos_rewinds: assert property (@(posedge clk) disable iff (rst)
    rd.pop |=> (pos == '0)) else $error("position not rewound after block");

endmodule

// ----- src/block_permutation_cipher_core.sv -----
// ----------------------------------------------------------------------------
// block_permutation_cipher_core
// Transposition cipher over blocks of up to sixteen bytes, with an APB-style
// configuration port.
// ----------------------------------------------------------------------------
// Message bytes enter one per cycle while byte_ready is high and are
// gathered into one of two block buffers; a block closes when it holds
// block_size bytes or when the byte marked end_of_message arrives, short
// blocks being filled with pad_byte. The closed block then leaves one
// permuted byte per cycle while res_ready allows; its first byte is loaded
// into the output register once the block is counted in the queue. The rate
// is set by the output stage, which reads one buffered byte per cycle unless
// the result port stalls; with both buffers full (one draining, one closed)
// input stalls until the draining block's last byte is issued. Registers
// sit at byte addresses 0 (block_size), 8 (decrypt_mode), 16 (key_map) and
// 24 (pad_byte); write them only while no block is pending.
module block_permutation_cipher_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          byte_valid,
  output logic                          byte_ready,
  input  bpc_pkg::in_item_t             byte_data,
  output logic                          res_valid,
  input  logic                          res_ready,
  output bpc_pkg::out_item_t            res_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bpc_pkg::PADDR_W-1:0]   paddr,
  input  logic [bpc_pkg::PDATA_W-1:0]   pwdata,
  output logic [bpc_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import bpc_pkg::*;

  logic [BS_W-1:0]     block_size;
  logic                decrypt_mode;
  logic [KEYMAP_W-1:0] key_map;
  logic [BYTE_W-1:0]   pad_byte;
  cfg_reg_e            reg_sel;
  logic                cfg_we;

  wr_req_t   wr;
  push_req_t push;
  rd_req_t   rd;
  head_t     head;
  logic      q_full;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_e'(paddr[4:3]);
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size   <= BS_W'(16);
      decrypt_mode <= 1'b0;
      key_map      <= '0;
      pad_byte     <= '0;
    end else if (cfg_we) begin
      unique case (reg_sel)
        REG_BLOCK_SIZE:   block_size   <= pwdata[BS_W-1:0];
        REG_DECRYPT_MODE: decrypt_mode <= pwdata[0];
        REG_KEY_MAP:      key_map      <= pwdata[KEYMAP_W-1:0];
        REG_PAD_BYTE:     pad_byte     <= pwdata[BYTE_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_BLOCK_SIZE:   prdata = PDATA_W'(block_size);
      REG_DECRYPT_MODE: prdata = PDATA_W'(decrypt_mode);
      REG_KEY_MAP:      prdata = PDATA_W'(key_map);
      REG_PAD_BYTE:     prdata = PDATA_W'(pad_byte);
    endcase
  end

  bpc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_data  (byte_data),
    .block_size (block_size),
    .q_full     (q_full),
    .wr         (wr),
    .push       (push)
  );

  bpc_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (wr),
    .push (push),
    .rd   (rd),
    .full (q_full),
    .head (head)
  );

  bpc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .rd           (rd),
    .decrypt_mode (decrypt_mode),
    .key_map      (key_map),
    .pad_byte     (pad_byte),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res_data     (res_data)
  );

endmodule

// ----- sim/block_permutation_cipher_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_permutation_cipher_core_test
// Self-checking bench for the block permutation cipher core.
// ----------------------------------------------------------------------------
// A short directed table covers reset defaults, block size clamping, out of
// range key entries in both directions, padding of short blocks and a block
// size lowered while bytes are held. Random phases follow, each with its own
// register setting, feeding messages of random length, with random input
// gaps and output stalls in all but the last. Every result transaction is
// compared with the bench's behavioral permutation model or a pinned value.
// ----------------------------------------------------------------------------
module block_permutation_cipher_core_test;
  import bpc_pkg::*;

  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 36;

  typedef struct {
    bit        is_cfg;
    cfg_reg_e  reg_sel;
    logic [63:0] value;
    in_item_t  item;
    bit        pinned;
    out_item_t pin;
  } step_row_t;

  logic                 clk;
  logic                 rst;
  logic                 byte_valid;
  logic                 byte_ready;
  in_item_t             byte_data;
  logic                 res_valid;
  logic                 res_ready;
  out_item_t            res_data;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  // Shadow of the configuration and the block being gathered.
  logic [BS_W-1:0]      cfg_size;
  logic                 cfg_decrypt;
  logic [KEYMAP_W-1:0]  cfg_key;
  logic [BYTE_W-1:0]    cfg_pad;
  logic [BYTE_W-1:0]    held_bytes [SIZE_CAP];
  int                   held_count;

  out_item_t            cipher_bytes_due[$];
  bit                   pin_armed;
  out_item_t            pin_value;
  bit                   quiet;
  int                   fault_count;
  int                   cycle_count;
  int                   stall_left;

  block_permutation_cipher_core dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_data  (byte_data),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_data   (res_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Take one byte into the shadow block; queue the permuted block once it closes.
  function automatic void cipher_accept(input in_item_t it, input bit pinned,
                                        input out_item_t pin);
    logic [BYTE_W-1:0] src [SIZE_CAP];
    logic [BYTE_W-1:0] dst [SIZE_CAP];
    out_item_t         res;
    int                size;
    int                p;
    size = (cfg_size == 0) ? 1 : ((cfg_size > SIZE_CAP) ? SIZE_CAP : int'(cfg_size));
    if (held_count < SIZE_CAP) begin
      held_bytes[held_count] = it.data_byte;
      held_count++;
    end
    if (held_count < size && !it.end_of_message) return;
    for (int k = 0; k < size; k++) begin
      src[k] = (k < held_count) ? held_bytes[k] : cfg_pad;
      dst[k] = cfg_pad;
    end
    // Ascending order lets the higher input index win on a shared target.
    for (int k = 0; k < size; k++) begin
      p = int'(cfg_key[KEY_W*k +: KEY_W]);
      if (cfg_decrypt) begin
        if (p < size) dst[k] = src[p];
      end else if (p < size) begin
        dst[p] = src[k];
      end
    end
    if (pinned) begin
      cipher_bytes_due.push_back(pin);
    end else begin
      for (int k = 0; k < size; k++) begin
        res.out_byte        = dst[k];
        res.last_of_block   = (k == size - 1);
        res.last_of_message = (k == size - 1) && it.end_of_message;
        cipher_bytes_due.push_back(res);
      end
    end
    held_count = 0;
  endfunction

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst) begin
      if (byte_valid && byte_ready) cipher_accept(byte_data, pin_armed, pin_value);
      if (res_valid && res_ready) begin
        if (cipher_bytes_due.size() == 0) begin
          $error("result transaction with none due: out_byte %h", res_data.out_byte);
          fault_count++;
        end else begin
          want = cipher_bytes_due.pop_front();
          if (res_data.out_byte !== want.out_byte) begin
            $error("out_byte expected %h got %h", want.out_byte, res_data.out_byte);
            fault_count++;
          end
          if (res_data.last_of_block !== want.last_of_block) begin
            $error("last_of_block expected %b got %b", want.last_of_block,
                   res_data.last_of_block);
            fault_count++;
          end
          if (res_data.last_of_message !== want.last_of_message) begin
            $error("last_of_message expected %b got %b", want.last_of_message,
                   res_data.last_of_message);
            fault_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Output backpressure in random bursts; no new burst once the run goes quiet.
  always @(negedge clk) begin
    if (!rst && stall_left > 0) begin
      res_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!rst && !quiet && $urandom_range(0, 5) == 0) begin
      res_ready  <= 1'b0;
      stall_left <= $urandom_range(1, 12) - 1;
    end else begin
      res_ready <= 1'b1;
    end
  end

  task automatic feed_byte(input in_item_t it, input int gap, input bit pinned,
                           input out_item_t pin);
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_data  <= it;
    byte_valid <= 1'b1;
    pin_armed  = pinned;
    pin_value  = pin;
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid, drain every due byte, then give the core time to go idle.
  task automatic settle();
    byte_valid <= 1'b0;
    while (cipher_bytes_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic reg_write(input cfg_reg_e r, input logic [63:0] val);
    logic [63:0] readback;
    logic [63:0] stored;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 3'b000};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    readback = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (r)
      REG_BLOCK_SIZE: begin
        cfg_size = val[BS_W-1:0];
        stored   = {{(64-BS_W){1'b0}}, val[BS_W-1:0]};
      end
      REG_DECRYPT_MODE: begin
        cfg_decrypt = val[0];
        stored      = {63'd0, val[0]};
      end
      REG_KEY_MAP: begin
        cfg_key = val;
        stored  = val;
      end
      default: begin
        cfg_pad = val[BYTE_W-1:0];
        stored  = {{(64-BYTE_W){1'b0}}, val[BYTE_W-1:0]};
      end
    endcase
    if (readback !== stored) begin
      $error("prdata for %s expected %h got %h", r.name(), stored, readback);
      fault_count++;
    end
    // Hold the bus idle before the next transfer.
    @(negedge clk);
  endtask

  function automatic step_row_t cfg_row(input cfg_reg_e r, input logic [63:0] val);
    step_row_t row;
    row         = '{reg_sel: REG_BLOCK_SIZE, default: '0};
    row.is_cfg  = 1'b1;
    row.reg_sel = r;
    row.value   = val;
    return row;
  endfunction

  function automatic step_row_t byte_row(input logic [7:0] b, input logic eom,
                                         input bit pinned, input out_item_t pin);
    step_row_t row;
    row                     = '{reg_sel: REG_BLOCK_SIZE, default: '0};
    row.item.data_byte      = b;
    row.item.end_of_message = eom;
    row.pinned              = pinned;
    row.pin                 = pin;
    return row;
  endfunction

  initial begin : stimulus
    step_row_t   directed_steps[$];
    step_row_t   row;
    in_item_t    it;
    out_item_t   none;
    int          order [SIZE_CAP];
    int          eff;
    int          j;
    int          tmp;
    int          msg_left;
    int          gap;
    logic [63:0] val;

    clk         = 1'b0;
    rst         = 1'b1;
    byte_valid  = 1'b0;
    byte_data   = '0;
    res_ready   = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    cfg_size    = 5'd16;
    cfg_decrypt = 1'b0;
    cfg_key     = '0;
    cfg_pad     = '0;
    held_count  = 0;
    pin_armed   = 1'b0;
    pin_value   = '0;
    quiet       = 1'b0;
    fault_count = 0;
    cycle_count = 0;
    stall_left  = 0;
    none        = '0;
    msg_left    = 0;

    // Reset defaults: sixteen-byte block, all key entries zero, so the last
    // input index lands on position zero and the rest is zero pad.
    directed_steps.push_back(byte_row(8'hA5, 1'b1, 1'b0, none));
    // Block size zero acts as one: the byte passes straight through.
    directed_steps.push_back(cfg_row(REG_BLOCK_SIZE, 64'd0));
    directed_steps.push_back(cfg_row(REG_PAD_BYTE, 64'h5A));
    directed_steps.push_back(byte_row(8'h00, 1'b0, 1'b1, out_item_t'{8'h00, 1'b1, 1'b0}));
    directed_steps.push_back(byte_row(8'hFF, 1'b1, 1'b1, out_item_t'{8'hFF, 1'b1, 1'b1}));
    // Key entry outside the block: dropped on encrypt, pad on decrypt.
    directed_steps.push_back(cfg_row(REG_KEY_MAP, 64'hF));
    directed_steps.push_back(byte_row(8'h3C, 1'b0, 1'b1, out_item_t'{8'h5A, 1'b1, 1'b0}));
    directed_steps.push_back(cfg_row(REG_DECRYPT_MODE, 64'd1));
    directed_steps.push_back(byte_row(8'hC3, 1'b1, 1'b1, out_item_t'{8'h5A, 1'b1, 1'b1}));
    directed_steps.push_back(cfg_row(REG_KEY_MAP, 64'd0));
    directed_steps.push_back(byte_row(8'h81, 1'b0, 1'b1, out_item_t'{8'h81, 1'b1, 1'b0}));
    // Oversized block clamps to sixteen; short message padded, reversed key.
    directed_steps.push_back(cfg_row(REG_BLOCK_SIZE, 64'd31));
    directed_steps.push_back(cfg_row(REG_DECRYPT_MODE, 64'd0));
    directed_steps.push_back(cfg_row(REG_KEY_MAP, 64'h0123_4567_89AB_CDEF));
    directed_steps.push_back(cfg_row(REG_PAD_BYTE, 64'hFF));
    for (int i = 0; i < 8; i++)
      directed_steps.push_back(byte_row(8'h10 + 8'(i), i == 7, 1'b0, none));
    // Hold ten bytes, then lower the block size under the held count.
    directed_steps.push_back(cfg_row(REG_BLOCK_SIZE, 64'd16));
    directed_steps.push_back(cfg_row(REG_DECRYPT_MODE, 64'd1));
    for (int i = 0; i < 10; i++)
      directed_steps.push_back(byte_row(8'hE0 + 8'(i), 1'b0, 1'b0, none));
    directed_steps.push_back(cfg_row(REG_BLOCK_SIZE, 64'd4));
    directed_steps.push_back(byte_row(8'h7E, 1'b0, 1'b0, none));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_steps[i]) begin
      row = directed_steps[i];
      if (row.is_cfg) begin
        settle();
        reg_write(row.reg_sel, row.value);
      end else begin
        gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
        feed_byte(row.item, gap, row.pinned, row.pin);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0:       eff = 16;
        1:       eff = 1;
        2:       eff = 31;
        3:       eff = 0;
        4:       eff = 2;
        5:       eff = 17;
        default: eff = $urandom_range(1, 16);
      endcase
      val = {$urandom, $urandom};
      val[BS_W-1:0] = BS_W'(eff);
      reg_write(REG_BLOCK_SIZE, val);
      reg_write(REG_DECRYPT_MODE, {$urandom, $urandom});
      reg_write(REG_PAD_BYTE, {$urandom, $urandom});
      eff = (eff == 0) ? 1 : ((eff > SIZE_CAP) ? SIZE_CAP : eff);
      val = {$urandom, $urandom};
      if ($urandom_range(0, 3) != 0) begin
        // Mostly a true permutation over the block, random above it.
        for (int k = 0; k < SIZE_CAP; k++) order[k] = k;
        for (int k = eff - 1; k > 0; k--) begin
          j        = $urandom_range(0, k);
          tmp      = order[k];
          order[k] = order[j];
          order[j] = tmp;
        end
        for (int k = 0; k < eff; k++) val[KEY_W*k +: KEY_W] = KEY_W'(order[k]);
      end
      reg_write(REG_KEY_MAP, val);
      quiet = (p == PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (msg_left == 0)
          msg_left = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3)
                                                 : $urandom_range(1, 40);
        it.data_byte      = BYTE_W'($urandom_range(0, 255));
        it.end_of_message = (msg_left == 1);
        msg_left--;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
        feed_byte(it, gap, 1'b0, none);
      end
    end

    settle();
    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/bpc_pkg.sv
src/bpc_front.sv
src/bpc_queue.sv
src/bpc_back.sv
src/block_permutation_cipher_core.sv
sim/block_permutation_cipher_core_test.sv
